// ----- rtl/pva_pkg.sv -----
package pva_pkg;

  // Voice count and derived widths.
  localparam int VOICES = 8;
  localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;

  // Field widths fixed by the item format.
  localparam int CMD_W  = 2;
  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int SEL_W  = 3;
  localparam int LVL_W  = 16;
  localparam int ACT_W  = 2;
  localparam int IDX_W  = 3;
  localparam int AMP_W  = VEL_W + LVL_W;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STATUS   = 2'd2;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_ATTACK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_NONE    = 2'd2;

  // Control from the sequencer to the amplitude compare unit.
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

endpackage

// ----- rtl/pva_req_if.sv -----
interface pva_req_if;
  logic                        valid;
  logic                        ready;
  logic [pva_pkg::CMD_W-1:0]   command;
  logic [pva_pkg::NOTE_W-1:0]  note;
  logic [pva_pkg::VEL_W-1:0]   velocity;
  logic [pva_pkg::SEL_W-1:0]   voice_select;
  logic [pva_pkg::LVL_W-1:0]   env_level;
  logic                        env_stopped;

  modport source (
    output valid, command, note, velocity, voice_select, env_level, env_stopped,
    input  ready
  );
  modport sink (
    input  valid, command, note, velocity, voice_select, env_level, env_stopped,
    output ready
  );
endinterface

// ----- rtl/pva_rsp_if.sv -----
interface pva_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pva_pkg::ACT_W-1:0]   action;
  logic [pva_pkg::IDX_W-1:0]   voice_index;
  logic [pva_pkg::NOTE_W-1:0]  voice_note;
  logic [pva_pkg::VEL_W-1:0]   voice_velocity;

  modport source (
    output valid, action, voice_index, voice_note, voice_velocity,
    input  ready
  );
  modport sink (
    input  valid, action, voice_index, voice_note, voice_velocity,
    output ready
  );
endinterface

// ----- rtl/pva_amp_unit.sv -----
module pva_amp_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  pva_pkg::scan_ctl_t        ctl,
  input  logic [pva_pkg::VW-1:0]    idx,
  input  logic [pva_pkg::VEL_W-1:0] vel,
  input  logic [pva_pkg::LVL_W-1:0] lvl,
  input  logic                      active,
  output logic                      steal_found,
  output logic [pva_pkg::VW-1:0]    steal_idx
);
  import pva_pkg::*;

  logic [AMP_W-1:0] amp;
  logic [AMP_W-1:0] best;
  logic             better;

  // One product of velocity and level per cycle, compared with the best so far.
  assign amp    = AMP_W'(vel) * AMP_W'(lvl);
  assign better = active && (!steal_found || (amp < best));

  // Keep the lowest-index active voice with the smallest product.
  always_ff @(posedge clk) begin
    if (rst) begin
      steal_found <= 1'b0;
    end else if (ctl.clear) begin
      steal_found <= 1'b0;
    end else if (ctl.step && better) begin
      steal_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && better) begin
      best      <= amp;
      steal_idx <= idx;
    end
  end

endmodule

// ----- rtl/poly_voice_allocator.sv -----
// A note item is captured, then scanned over every voice in S_SCAN, and finishes
// in S_DONE once the result register is free; a status or unused item goes to S_DONE.
// No new item is taken until the last one has finished. The scan reads one voice
// a cycle through a single shared multiply and compare unit.
// Reset: synchronous rst clears all voice notes, velocities, levels and active
// flags to zero, empties the result register and returns the sequencer to idle.
module poly_voice_allocator (
  input  logic      clk,
  input  logic      rst,
  pva_req_if.sink   req,
  pva_rsp_if.source rsp
);
  import pva_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;

  // Voice state.
  logic [NOTE_W-1:0] note_mem [VOICES];
  logic [VEL_W-1:0]  vel_mem  [VOICES];
  logic [LVL_W-1:0]  lvl_mem  [VOICES];
  logic [VOICES-1:0] act_mem;

  // Captured item.
  logic [CMD_W-1:0]  cmd_q;
  logic [NOTE_W-1:0] note_q;
  logic [VEL_W-1:0]  vel_q;
  logic [SEL_W-1:0]  sel_q;
  logic [LVL_W-1:0]  lvl_q;
  logic              stop_q;

  // Scan results.
  logic [VW-1:0]     idx;
  logic              retrig_found;
  logic [VW-1:0]     retrig_idx;
  logic              free_found;
  logic [VW-1:0]     free_idx;
  logic              hit_found;
  logic [VW-1:0]     hit_idx;
  logic [VEL_W-1:0]  hit_vel;
  logic              steal_found;
  logic [VW-1:0]     steal_idx;

  // Result register.
  logic              out_valid;
  logic [ACT_W-1:0]  out_action;
  logic [IDX_W-1:0]  out_index;
  logic [NOTE_W-1:0] out_note;
  logic [VEL_W-1:0]  out_vel;

  scan_ctl_t         ctl;
  logic              req_fire;
  logic              out_free;
  logic              finish;
  logic              cur_match;
  logic              cur_active;
  logic [VW-1:0]     pick;
  logic              sel_ok;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign finish    = (state == S_DONE) && out_free;

  assign cur_match  = (note_mem[idx] == note_q);
  assign cur_active = act_mem[idx];
  assign sel_ok     = (32'(sel_q) < VOICES);

  assign ctl.clear = req_fire;
  assign ctl.step  = (state == S_SCAN);

  pva_amp_unit u_amp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .idx         (idx),
    .vel         (vel_mem[idx]),
    .lvl         (lvl_mem[idx]),
    .active      (cur_active),
    .steal_found (steal_found),
    .steal_idx   (steal_idx)
  );

  // Voice chosen for a note-on: retrigger, then free voice, then steal.
  always_comb begin
    priority if (retrig_found) begin
      pick = retrig_idx;
    end else if (free_found) begin
      pick = free_idx;
    end else if (steal_found) begin
      pick = steal_idx;
    end else begin
      pick = '0;
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      // The result becomes valid as an item finishes and clears on its transfer.
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            idx <= '0;
            if (req.command == CMD_NOTE_ON || req.command == CMD_NOTE_OFF) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (idx == VW'(VOICES - 1)) begin
            state <= S_DONE;
          end else begin
            idx <= idx + VW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload, loaded as the item finishes.
  always_ff @(posedge clk) begin
    if (finish) begin
      if (cmd_q == CMD_NOTE_ON) begin
        out_action <= ACT_ATTACK;
        out_index  <= IDX_W'(pick);
        out_note   <= note_q;
        out_vel    <= vel_q;
      end else if (cmd_q == CMD_NOTE_OFF && hit_found) begin
        out_action <= ACT_RELEASE;
        out_index  <= IDX_W'(hit_idx);
        out_note   <= note_q;
        out_vel    <= hit_vel;
      end else begin
        out_action <= ACT_NONE;
        out_index  <= '0;
        out_note   <= '0;
        out_vel    <= '0;
      end
    end
  end

  // Item capture and per-voice scan flags; later matches overwrite earlier ones.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd_q        <= req.command;
      note_q       <= req.note;
      vel_q        <= req.velocity;
      sel_q        <= req.voice_select;
      lvl_q        <= req.env_level;
      stop_q       <= req.env_stopped;
      retrig_found <= 1'b0;
      free_found   <= 1'b0;
      hit_found    <= 1'b0;
    end else if (state == S_SCAN) begin
      if (cur_match) begin
        retrig_found <= 1'b1;
        retrig_idx   <= idx;
      end
      if (!cur_active) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
      if (cur_match && cur_active) begin
        hit_found <= 1'b1;
        hit_idx   <= idx;
        hit_vel   <= vel_mem[idx];
      end
    end
  end

  // Voice state update: note-on stores note and velocity, status sets level and flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        note_mem[i] <= '0;
        vel_mem[i]  <= '0;
        lvl_mem[i]  <= '0;
      end
      act_mem <= '0;
    end else if (finish) begin
      if (cmd_q == CMD_NOTE_ON) begin
        note_mem[pick] <= note_q;
        vel_mem[pick]  <= vel_q;
      end else if (cmd_q == CMD_STATUS && sel_ok) begin
        lvl_mem[VW'(sel_q)] <= lvl_q;
        act_mem[VW'(sel_q)] <= !stop_q;
      end
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.action         = out_action;
  assign rsp.voice_index    = out_index;
  assign rsp.voice_note     = out_note;
  assign rsp.voice_velocity = out_vel;

endmodule
